### rtl/hrc_pkg.sv
// hrc_pkg: shared constants, codes and types of the hashed ttl result cache
// used by every module under rtl but hrc_ram; depends on nothing

package hrc_pkg;

   // slot store geometry
   localparam int          SLOTS     = 512;
   localparam int          SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [31:0] SLOT_MASK = 32'(SLOTS - 1);

   // hash constants
   localparam logic [31:0] HASH_MUL_A = 32'd2654435761;
   localparam logic [31:0] HASH_MUL_B = 32'd2246822519;
   localparam int          HASH_SHIFT = 16;

   // time-to-live register reset value
   localparam logic [31:0] TTL_RESET = 32'd10000;

   // stream widths
   localparam int REQ_DATA_W = 192;
   localparam int RSP_DATA_W = 32;

   // operation codes
   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_STORE  = 1'b1;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_MISS          = 2'd0,
      STATUS_HIT_FOUND     = 2'd1,
      STATUS_HIT_NOT_FOUND = 2'd2
   } hrc_status_type;

   // request tdata layout, last field in the lowest bits
   typedef struct packed {
      logic        pad;
      logic [31:0] now_ms;
      logic [30:0] store_days;
      logic        store_found;
      logic [30:0] threshold_key;
      logic [31:0] player_key;
      logic [63:0] context_id;
   } hrc_req_type;

   // one slot of the store
   typedef struct packed {
      logic        valid;
      logic [63:0] context_id;
      logic [31:0] player_key;
      logic [30:0] threshold_key;
      logic [31:0] stamp;
      logic        found;
      logic [30:0] days;
   } hrc_entry_type;

   localparam int ENTRY_W = $bits(hrc_entry_type);

   // controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic mul_player;
      logic mul_thresh;
      logic ram_rd;
      logic store_wr;
      logic clear_wr;
      logic load_rsp;
   } hrc_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_store;
      logic clear_last;
   } hrc_stat_type;

endpackage

### rtl/hashed_ttl_result_cache.sv
// hashed_ttl_result_cache: direct-mapped result cache with time-to-live expiry
// an item runs through the shared hash multiplier (player key, then threshold key) and
// the registered slot store read or write; the next item is taken only once the result is loaded
// reset: ttl_ms returns to 10000 and a clearing pass writes all SLOTS (512) slots,
// during which no item is accepted; csr writes are taken throughout
// uses hrc_pkg, hrc_ctrl, hrc_dpath, hrc_ram

module hashed_ttl_result_cache (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // context_id, player_key, threshold_key, store_found, store_days, now_ms, zero
   input  logic [hrc_pkg::REQ_DATA_W-1:0]  req_tdata,
   // op
   input  logic [0:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // hit_days, zero
   output logic [hrc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // lookup_status
   output logic [1:0]                      rsp_tuser,
   input  logic                            csr_wr_en,
   input  logic [31:0]                     csr_wr_data
);

   hrc_pkg::hrc_cmd_type  cmd;
   hrc_pkg::hrc_stat_type stat;

   // sequencing
   hrc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // hashing, slot store and result
   hrc_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat)
   );

   // no item taken while the clearing pass runs
   assert property (@(posedge clock) disable iff (reset) cmd.clear_wr |-> !req_tready)
      else $error("item accepted during clearing pass");

   // one item at a time: the cycle after an accept takes nothing
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item accepted while one is in work");

   // slot store ports never contend
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_wr, cmd.store_wr, cmd.ram_rd}))
      else $error("conflicting slot store commands");

   // a loaded result is offered in the next cycle
   assert property (@(posedge clock) disable iff (reset) cmd.load_rsp |=> rsp_tvalid)
      else $error("result loaded but not offered");

endmodule

### rtl/hrc_ram.sv
// hrc_ram: generic single-write, single-read memory with registered read data
// stands alone, no package needed

module hrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/hrc_ctrl.sv
// hrc_ctrl: sequencing state machine of the result cache
// uses hrc_pkg command and status types

module hrc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  hrc_pkg::hrc_stat_type stat,
   output hrc_pkg::hrc_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MUL_PLAYER,
      S_MUL_THRESH,
      S_ACCESS,
      S_RESPOND
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_MUL_PLAYER;
            end
         end
         S_MUL_PLAYER: begin
            cmd.mul_player = 1'b1;
            state_in       = S_MUL_THRESH;
         end
         S_MUL_THRESH: begin
            cmd.mul_thresh = 1'b1;
            state_in       = S_ACCESS;
         end
         S_ACCESS: begin
            // a store writes the slot, a lookup reads it
            if (stat.is_store) begin
               cmd.store_wr = 1'b1;
            end else begin
               cmd.ram_rd = 1'b1;
            end
            state_in = S_RESPOND;
         end
         S_RESPOND: begin
            // wait for room in the output register
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register valid
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

### rtl/hrc_dpath.sv
// hrc_dpath: request registers, shared hash multiplier, slot store and result register
// uses hrc_pkg and hrc_ram

module hrc_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [hrc_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [0:0]                          req_tuser,
   output logic [hrc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [1:0]                          rsp_tuser,
   input  logic                                csr_wr_en,
   input  logic [31:0]                         csr_wr_data,
   input  hrc_pkg::hrc_cmd_type                cmd,
   output hrc_pkg::hrc_stat_type               stat
);

   hrc_pkg::hrc_req_type   req_view;
   hrc_pkg::hrc_entry_type wr_entry;
   hrc_pkg::hrc_entry_type rd_entry;
   hrc_pkg::hrc_status_type status_in;
   hrc_pkg::hrc_status_type status_ff;

   logic        op_ff;
   logic [63:0] ctx_ff;
   logic [31:0] player_ff;
   logic [30:0] thresh_ff;
   logic        sfound_ff;
   logic [30:0] sdays_ff;
   logic [31:0] now_ff;
   logic [31:0] ttl_ff;

   logic [31:0] mul_operand;
   logic [31:0] mul_const;
   logic [31:0] mul_out;
   logic [31:0] prod_p_ff;
   logic [31:0] hash_xor;
   logic [31:0] hash_mix;
   logic [31:0] hash_masked;
   logic [hrc_pkg::SLOT_BITS-1:0] slot_ff;
   logic [hrc_pkg::SLOT_BITS-1:0] clear_cnt_ff;
   logic [hrc_pkg::SLOT_BITS-1:0] wr_addr;
   logic [hrc_pkg::ENTRY_W-1:0]   wr_data;
   logic [hrc_pkg::ENTRY_W-1:0]   rd_data;
   logic [31:0] age;
   logic        hit;
   logic [30:0] days_in;
   logic [30:0] days_ff;

   assign req_view = hrc_pkg::hrc_req_type'(req_tdata);

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff     <= req_tuser[0];
         ctx_ff    <= req_view.context_id;
         player_ff <= req_view.player_key;
         thresh_ff <= req_view.threshold_key;
         sfound_ff <= req_view.store_found;
         sdays_ff  <= req_view.store_days;
         now_ff    <= req_view.now_ms;
      end
   end

   // time-to-live register
   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff <= hrc_pkg::TTL_RESET;
      end else if (csr_wr_en) begin
         ttl_ff <= csr_wr_data;
      end
   end

   // shared hash multiplier, low 32 bits of the product
   assign mul_operand = cmd.mul_thresh ? {1'b0, thresh_ff} : player_ff;
   assign mul_const   = cmd.mul_thresh ? hrc_pkg::HASH_MUL_B : hrc_pkg::HASH_MUL_A;
   assign mul_out     = mul_operand * mul_const;

   // fold the two products and reduce to a slot index
   assign hash_xor    = prod_p_ff ^ mul_out;
   assign hash_mix    = hash_xor ^ (hash_xor >> hrc_pkg::HASH_SHIFT);
   assign hash_masked = hash_mix & hrc_pkg::SLOT_MASK;

   always_ff @(posedge clock) begin
      if (cmd.mul_player) begin
         prod_p_ff <= mul_out;
      end
      if (cmd.mul_thresh) begin
         slot_ff <= hash_masked[hrc_pkg::SLOT_BITS-1:0];
      end
   end

   // clearing sweep after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
      end else if (cmd.clear_wr) begin
         clear_cnt_ff <= clear_cnt_ff + 1'b1;
      end
   end

   assign stat.clear_last = (clear_cnt_ff == hrc_pkg::SLOT_BITS'(hrc_pkg::SLOTS - 1));
   assign stat.is_store   = (op_ff == hrc_pkg::OP_STORE);

   // slot write data
   always_comb begin
      wr_entry.valid         = 1'b1;
      wr_entry.context_id    = ctx_ff;
      wr_entry.player_key    = player_ff;
      wr_entry.threshold_key = thresh_ff;
      wr_entry.stamp         = now_ff;
      wr_entry.found         = sfound_ff;
      wr_entry.days          = sdays_ff;
   end

   assign wr_addr = cmd.clear_wr ? clear_cnt_ff : slot_ff;
   assign wr_data = cmd.clear_wr ? '0 : wr_entry;

   hrc_ram #(
      .WIDTH (hrc_pkg::ENTRY_W),
      .DEPTH (hrc_pkg::SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (cmd.clear_wr | cmd.store_wr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.ram_rd),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   assign rd_entry = hrc_pkg::hrc_entry_type'(rd_data);

   // tag match and wrapping age check
   assign age = now_ff - rd_entry.stamp;
   assign hit = rd_entry.valid
             && (rd_entry.context_id == ctx_ff)
             && (rd_entry.player_key == player_ff)
             && (rd_entry.threshold_key == thresh_ff)
             && (age <= ttl_ff);

   always_comb begin
      status_in = hrc_pkg::STATUS_MISS;
      days_in   = '0;
      if (!stat.is_store && hit) begin
         status_in = rd_entry.found ? hrc_pkg::STATUS_HIT_FOUND
                                    : hrc_pkg::STATUS_HIT_NOT_FOUND;
         days_in   = rd_entry.days;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         status_ff <= status_in;
         days_ff   <= days_in;
      end
   end

   assign rsp_tuser = status_ff;
   assign rsp_tdata = {1'b0, days_ff};

endmodule

### dv/hrc_result_checker.sv
// hrc_result_checker: watches both streams and the csr port of the result cache,
// predicts every response from its own copy of the slot store and compares it
// depends on hrc_pkg for the request layout, geometry, hash and status constants

module hrc_result_checker
   import hrc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic [0:0]             req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic [1:0]             rsp_tuser,
   input  logic                   csr_wr_en,
   input  logic [31:0]            csr_wr_data,
   output int                     fail_count,
   output int unsigned            outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // one predicted response
   typedef struct packed {
      logic [1:0]  status;
      logic [30:0] days;
   } outcome_type;

   // own copy of the store and the ttl register
   logic        slot_valid     [SLOTS];
   logic [63:0] slot_context   [SLOTS];
   logic [31:0] slot_player    [SLOTS];
   logic [30:0] slot_threshold [SLOTS];
   logic [31:0] slot_stamp     [SLOTS];
   logic        slot_found     [SLOTS];
   logic [30:0] slot_days      [SLOTS];
   logic [31:0] ttl_copy;

   outcome_type outcome_q[$];

   // multiplicative hash of the two keys down to a slot index
   function automatic int unsigned slot_of_key(logic [31:0] player, logic [30:0] thresh);
      logic [31:0] h;
      h = player * HASH_MUL_A;
      h = h ^ ({1'b0, thresh} * HASH_MUL_B);
      h = h ^ (h >> HASH_SHIFT);
      return int'(h & SLOT_MASK);
   endfunction

   // apply one item to the store copy and return what the cache should answer
   function automatic outcome_type cache_outcome(logic op, hrc_req_type r);
      outcome_type res;
      int unsigned s;
      logic [31:0] age;
      s = slot_of_key(r.player_key, r.threshold_key);
      res.status = STATUS_MISS;
      res.days = '0;
      if (op == OP_STORE) begin
         slot_valid[s] = 1'b1;
         slot_context[s] = r.context_id;
         slot_player[s] = r.player_key;
         slot_threshold[s] = r.threshold_key;
         slot_stamp[s] = r.now_ms;
         slot_found[s] = r.store_found;
         slot_days[s] = r.store_days;
      end else begin
         age = r.now_ms - slot_stamp[s];
         if (slot_valid[s] && slot_context[s] == r.context_id
             && slot_player[s] == r.player_key
             && slot_threshold[s] == r.threshold_key && age <= ttl_copy) begin
            res.status = slot_found[s] ? STATUS_HIT_FOUND : STATUS_HIT_NOT_FOUND;
            res.days = slot_days[s];
         end
      end
      return res;
   endfunction

   // retire responses first, then queue the prediction for a newly taken item
   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         ttl_copy = TTL_RESET;
         for (int i = 0; i < SLOTS; i++) slot_valid[i] = 1'b0;
         outcome_q.delete();
         fail_count = 0;
         outstanding <= 0;
      end else begin
         if (csr_wr_en) ttl_copy = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (outcome_q.size() == 0) begin
               $error("response with no item waiting: lookup_status %0d hit_days %0d",
                      rsp_tuser, rsp_tdata[30:0]);
               fail_count++;
            end else begin
               want = outcome_q.pop_front();
               if (rsp_tuser !== want.status) begin
                  $error("lookup_status mismatch: expected %0d, actual %0d",
                         want.status, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[30:0] !== want.days) begin
                  $error("hit_days mismatch: expected %0d, actual %0d",
                         want.days, rsp_tdata[30:0]);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            outcome_q.push_back(cache_outcome(req_tuser[0], hrc_req_type'(req_tdata)));
         outstanding <= outcome_q.size();
      end
   end

endmodule

### dv/tb_hashed_ttl_result_cache.sv
// tb_hashed_ttl_result_cache: drives lookups and stores into the result cache
// through several ttl settings with bursty input and a stalling receiver
// depends on hrc_pkg, hashed_ttl_result_cache and hrc_result_checker

module tb_hashed_ttl_result_cache;
   timeunit 1ns;
   timeprecision 1ps;
   import hrc_pkg::*;

   localparam int KEY_POOL   = 48;
   localparam int QUIET_MAX  = 4000;
   localparam int LONG_HOLD  = 400;

   typedef enum {RX_READY, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_wr_en = 1'b0;
   logic [31:0]           csr_wr_data = '0;

   int                    fail_count;
   int unsigned           outstanding;
   int                    quiet_cycles = 0;
   logic                  long_hold_req = 1'b0;
   int                    burst_left = 0;
   logic [31:0]           cur_ttl = TTL_RESET;
   logic [31:0]           stamp_clock;

   // key pool so that lookups find what was stored
   logic [63:0] key_ctx    [KEY_POOL];
   logic [31:0] key_player [KEY_POOL];
   logic [30:0] key_thr    [KEY_POOL];
   logic [31:0] key_stamp  [KEY_POOL];

   hashed_ttl_result_cache dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   hrc_result_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // cycles in which neither stream moves an item
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_MAX) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   // receiver: stall pattern of its own, plus one long hold-off on request
   initial begin
      rx_mode_type mode;
      int mode_left;
      int hold_left;
      int tick;
      bit hold_done;
      mode = RX_READY;
      mode_left = 0;
      hold_left = 0;
      tick = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (mode_left == 0) begin
            mode = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         if (long_hold_req && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               RX_READY:  rsp_tready <= 1'b1;
               RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_tready <= (tick % 4 == 0);
               default:   rsp_tready <= ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   function automatic hrc_req_type make_req(logic [63:0] ctx, logic [31:0] player,
                                            logic [30:0] thresh, logic found,
                                            logic [30:0] days, logic [31:0] now);
      hrc_req_type r;
      r.pad = 1'b0;
      r.context_id = ctx;
      r.player_key = player;
      r.threshold_key = thresh;
      r.store_found = found;
      r.store_days = days;
      r.now_ms = now;
      return r;
   endfunction

   // offer one item, with a random gap between bursts, and wait until taken
   task automatic offer(input logic op, input hrc_req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tdata <= r;
      req_tuser <= op;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // drain every response, then write the ttl register while idle
   task automatic write_ttl(input logic [31:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      cur_ttl = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // field extremes, every tag mismatch, ttl boundary and age wrap
   task automatic directed_items();
      hrc_req_type a;
      hrc_req_type b;
      a = make_req('1, '1, '1, 1'b1, '1, '1);
      offer(OP_LOOKUP, a);                       // empty cache
      offer(OP_STORE, a);
      offer(OP_LOOKUP, a);                       // age zero
      a.now_ms = 32'hFFFF_FFFF + TTL_RESET;      // age exactly ttl
      offer(OP_LOOKUP, a);
      a.now_ms = 32'hFFFF_FFFF + TTL_RESET + 1;  // one past ttl
      offer(OP_LOOKUP, a);
      a.now_ms = '1;
      b = a;
      b.context_id[0] = 1'b0;
      offer(OP_LOOKUP, b);
      b = a;
      b.player_key[31] = 1'b0;
      offer(OP_LOOKUP, b);
      b = a;
      b.threshold_key[15] = 1'b0;
      offer(OP_LOOKUP, b);
      // all-zero key, threshold zero included
      b = make_req('0, '0, '0, 1'b0, '0, '0);
      offer(OP_STORE, b);
      offer(OP_LOOKUP, b);
      // store fields on a lookup are ignored
      b = make_req('0, '0, '0, 1'b1, '1, 32'd5);
      offer(OP_LOOKUP, b);
      b = make_req('0, '0, 31'd1, 1'b0, 31'd12345, 32'd100);
      offer(OP_STORE, b);
      b.now_ms = 32'd100 + TTL_RESET;
      offer(OP_LOOKUP, b);
      // overwrite of a live entry
      a.store_found = 1'b0;
      a.store_days = 31'd5;
      a.now_ms = 32'd500;
      offer(OP_STORE, a);
      offer(OP_LOOKUP, a);
      // age across the wrap of the millisecond tick
      b = make_req(64'h0123_4567_89AB_CDEF, 32'h8000_0000, 31'h4000_0000, 1'b1,
                   31'd77, 32'hFFFF_FFF0);
      offer(OP_STORE, b);
      b.now_ms = 32'd10;
      offer(OP_LOOKUP, b);
   endtask

   // mostly stores and lookups on the key pool, some broken tags and noise
   task automatic random_phase(input int count, input int hold_at);
      int k;
      int pick;
      int sel;
      int idx;
      logic op;
      logic [31:0] age;
      hrc_req_type r;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(0, KEY_POOL - 1);
         pick = $urandom_range(0, 99);
         r = make_req(key_ctx[k], key_player[k], key_thr[k], 1'($urandom),
                      31'($urandom), $urandom);
         if ($urandom_range(0, 9) == 0) r.store_days = '1;
         else if ($urandom_range(0, 9) == 0) r.store_days = '0;
         if (pick < 40) begin
            op = OP_STORE;
            if (pick >= 4) begin
               r.now_ms = stamp_clock;
               stamp_clock += $urandom_range(0, 3000);
            end
            key_stamp[k] = r.now_ms;
         end else if (pick < 90) begin
            op = OP_LOOKUP;
            sel = $urandom_range(0, 5);
            if (sel == 0) age = '0;
            else if (sel == 1) age = cur_ttl;
            else if (sel == 2) age = cur_ttl + 1;
            else if (sel == 3) age = $urandom_range(0, 255);
            else if (sel == 4) age = $urandom;
            else age = cur_ttl - $urandom_range(0, 15);
            r.now_ms = key_stamp[k] + age;
            // one tag bit flipped: same slot or a different one, never a hit
            if (pick >= 78) begin
               sel = $urandom_range(0, 2);
               if (sel == 0) begin
                  idx = $urandom_range(0, 63);
                  r.context_id[idx] = ~r.context_id[idx];
               end else if (sel == 1) begin
                  idx = $urandom_range(0, 31);
                  r.player_key[idx] = ~r.player_key[idx];
               end else begin
                  idx = $urandom_range(0, 30);
                  r.threshold_key[idx] = ~r.threshold_key[idx];
               end
            end
         end else begin
            op = 1'($urandom);
            r = make_req({$urandom, $urandom}, $urandom, 31'($urandom), 1'($urandom),
                         31'($urandom), $urandom);
         end
         if (i == hold_at) long_hold_req <= 1'b1;
         offer(op, r);
      end
   endtask

   // main sequence
   initial begin
      stamp_clock = $urandom;
      key_ctx[0] = '0;
      key_player[0] = '0;
      key_thr[0] = '0;
      key_ctx[1] = '1;
      key_player[1] = '1;
      key_thr[1] = '1;
      for (int i = 2; i < KEY_POOL; i++) begin
         // a few keys share a context word
         key_ctx[i] = (i % 5 == 0) ? key_ctx[i - 1] : {$urandom, $urandom};
         key_player[i] = $urandom;
         key_thr[i] = ($urandom_range(0, 7) == 0) ? 31'($urandom_range(1, 16))
                                                   : 31'($urandom);
      end
      for (int i = 0; i < KEY_POOL; i++) key_stamp[i] = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      directed_items();
      random_phase(350, 120);
      write_ttl(32'd0);
      random_phase(350, -1);
      write_ttl(32'hFFFF_FFFF);
      random_phase(350, -1);
      write_ttl($urandom);
      random_phase(350, -1);
      write_ttl($urandom_range(1, 64));
      random_phase(350, -1);

      // let the last responses out
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### sim.f
rtl/hrc_pkg.sv
rtl/hrc_ram.sv
rtl/hrc_ctrl.sv
rtl/hrc_dpath.sv
rtl/hashed_ttl_result_cache.sv
dv/hrc_result_checker.sv
dv/tb_hashed_ttl_result_cache.sv
